/* hdl/qwt_pkg.sv */
// ----------------------------------------------------------------------------
// qwt_pkg
// Shared types and constants of the quoted word tokenizer: character codes,
// result kinds, the result record and the sizes of the result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qwt_pkg;

	// Default size limits
	localparam int MAX_WORD_LEN_DEF = 32;
	localparam int MAX_WORDS_DEF    = 16;

	// Character codes
	localparam logic [7:0] CH_END   = 8'd0;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_UC_A  = 8'd65;
	localparam logic [7:0] CH_UC_Z  = 8'd90;
	localparam logic [7:0] CASE_OFS = 8'd32;

	// Results caused by one character, at most
	localparam int MAX_RESULTS = 3;
	localparam int RES_CNT_W   = 2;

	// Result buffer
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_EOW  = 2'd1,
		KIND_EOL  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_char;
		logic [3:0] word_index;
		logic [4:0] word_count;
		logic       truncated;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

/* hdl/qwt_tokenizer.sv */
// ----------------------------------------------------------------------------
// qwt_tokenizer
// Tokenizer state and the single-pass step logic: one character in, up to
// three result records out, state updated when the character is consumed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qwt_tokenizer #(
	parameter int MAX_WORD_LEN = qwt_pkg::MAX_WORD_LEN_DEF,
	parameter int MAX_WORDS    = qwt_pkg::MAX_WORDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [7:0]                    ch,
	output qwt_pkg::res_t                      res [qwt_pkg::MAX_RESULTS],
	output logic [qwt_pkg::RES_CNT_W-1:0]      res_cnt
);

	localparam int LenW = $clog2(MAX_WORD_LEN + 1);
	localparam int CntW = $clog2(MAX_WORDS + 1);

	logic            between_q, in_quote_q, held_q, comment_q, ovf_q;
	logic [LenW-1:0] len_q;
	logic [CntW-1:0] words_q;

	logic            between_d, in_quote_d, held_d, comment_d, ovf_d;
	logic [LenW-1:0] len_d;
	logic [CntW-1:0] words_d;

	// Step logic for one character
	always_comb begin
		logic [7:0]                   lc;
		logic                         is_end, do_start, do_add, do_finish, skip;
		logic [qwt_pkg::RES_CNT_W-1:0] n;

		between_d  = between_q;
		in_quote_d = in_quote_q;
		held_d     = held_q;
		comment_d  = comment_q;
		ovf_d      = ovf_q;
		len_d      = len_q;
		words_d    = words_q;
		n          = '0;
		skip       = 1'b0;
		for (int i = 0; i < qwt_pkg::MAX_RESULTS; i++) begin
			res[i] = '0;
		end

		lc = (ch >= qwt_pkg::CH_UC_A && ch <= qwt_pkg::CH_UC_Z) ? ch + qwt_pkg::CASE_OFS : ch;

		is_end    = (ch == qwt_pkg::CH_END);
		do_start  = between_q && !is_end && ch != qwt_pkg::CH_SPACE;
		do_add    = !is_end && ch != qwt_pkg::CH_QUOTE
			&& ((between_q && ch != qwt_pkg::CH_SPACE)
			|| (!between_q && in_quote_q)
			|| (!between_q && !in_quote_q && ch != qwt_pkg::CH_SPACE));
		do_finish = (is_end && !between_q)
			|| (!between_q && in_quote_q && ch == qwt_pkg::CH_QUOTE)
			|| (!between_q && !in_quote_q && ch == qwt_pkg::CH_SPACE);

		// Word start; a word beyond the count limit is dropped whole
		if (do_start) begin
			between_d = 1'b0;
			len_d     = '0;
			held_d    = 1'b0;
			if (!comment_d && words_d >= CntW'(MAX_WORDS)) begin
				ovf_d = 1'b1;
			end
			if (ch == qwt_pkg::CH_QUOTE) begin
				in_quote_d = 1'b1;
			end
		end

		// Word character, with a leading slash held back
		if (do_add && !(comment_d || words_d >= CntW'(MAX_WORDS))) begin
			if (len_d == '0 && lc == qwt_pkg::CH_SLASH) begin
				held_d = 1'b1;
				len_d  = LenW'(1);
			end else begin
				if (held_d) begin
					held_d = 1'b0;
					if (lc == qwt_pkg::CH_SLASH) begin
						comment_d = 1'b1;
						skip      = 1'b1;
					end else begin
						res[n].kind       = qwt_pkg::KIND_CHAR;
						res[n].out_char   = qwt_pkg::CH_SLASH;
						res[n].word_index = 4'(words_d);
						n = n + 1'b1;
					end
				end
				if (!skip) begin
					if (len_d >= LenW'(MAX_WORD_LEN)) begin
						ovf_d = 1'b1;
					end else begin
						res[n].kind       = qwt_pkg::KIND_CHAR;
						res[n].out_char   = lc;
						res[n].word_index = 4'(words_d);
						n = n + 1'b1;
						len_d = len_d + 1'b1;
					end
				end
			end
		end

		// Word end; a lone slash goes out ahead of the end-of-word
		if (do_finish) begin
			between_d  = 1'b1;
			in_quote_d = 1'b0;
			if (!(comment_d || words_d >= CntW'(MAX_WORDS))) begin
				if (held_d) begin
					held_d = 1'b0;
					res[n].kind       = qwt_pkg::KIND_CHAR;
					res[n].out_char   = qwt_pkg::CH_SLASH;
					res[n].word_index = 4'(words_d);
					n = n + 1'b1;
				end
				res[n].kind       = qwt_pkg::KIND_EOW;
				res[n].word_index = 4'(words_d);
				n = n + 1'b1;
				words_d = words_d + 1'b1;
			end
		end

		// End of line: summary, then back to the line-start state
		if (is_end) begin
			res[n].kind       = qwt_pkg::KIND_EOL;
			res[n].word_count = 5'(words_d);
			res[n].truncated  = ovf_d;
			n = n + 1'b1;
			between_d  = 1'b1;
			in_quote_d = 1'b0;
			held_d     = 1'b0;
			comment_d  = 1'b0;
			ovf_d      = 1'b0;
			len_d      = '0;
			words_d    = '0;
		end

		// Mark the final result of this character
		for (int i = 0; i < qwt_pkg::MAX_RESULTS; i++) begin
			res[i].last = (n != '0) && (qwt_pkg::RES_CNT_W'(i) == n - 1'b1);
		end
		res_cnt = n;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			between_q  <= 1'b1;
			in_quote_q <= 1'b0;
			held_q     <= 1'b0;
			comment_q  <= 1'b0;
			ovf_q      <= 1'b0;
			len_q      <= '0;
			words_q    <= '0;
		end else if (fire) begin
			between_q  <= between_d;
			in_quote_q <= in_quote_d;
			held_q     <= held_d;
			comment_q  <= comment_d;
			ovf_q      <= ovf_d;
			len_q      <= len_d;
			words_q    <= words_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/qwt_result_fifo.sv */
// ----------------------------------------------------------------------------
// qwt_result_fifo
// Four-entry result buffer: takes up to three records in a cycle, hands out
// one per transaction on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qwt_result_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire qwt_pkg::res_t                 push_res [qwt_pkg::MAX_RESULTS],
	input  wire logic [qwt_pkg::RES_CNT_W-1:0] push_cnt,
	output logic                               room,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output qwt_pkg::res_t                      head
);

	qwt_pkg::res_t                   mem_q [qwt_pkg::FIFO_DEPTH];
	logic [qwt_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [qwt_pkg::FIFO_CNT_W-1:0] count_q;
	logic                            pop;

	// Status
	assign room      = count_q <= qwt_pkg::FIFO_CNT_W'(qwt_pkg::FIFO_DEPTH - qwt_pkg::MAX_RESULTS);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < qwt_pkg::MAX_RESULTS; i++) begin
			if (qwt_pkg::RES_CNT_W'(i) < push_cnt) begin
				mem_q[wr_q + qwt_pkg::FIFO_PTR_W'(i)] <= push_res[i];
			end
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + qwt_pkg::FIFO_PTR_W'(push_cnt);
			rd_q    <= rd_q + qwt_pkg::FIFO_PTR_W'(pop);
			count_q <= count_q + qwt_pkg::FIFO_CNT_W'(push_cnt)
				- qwt_pkg::FIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* hdl/quoted_word_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_core
// Splits a zero-terminated line of characters into words and streams each
// word out as character records followed by an end-of-word record.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, ch) carries one character per
//   transaction; a zero byte ends the line. Output channel (out_valid,
//   out_stall, kind, out_char, word_index, word_count, truncated, last)
//   carries one result record per transaction; last marks the final record
//   caused by a character, which may cause none, one, two or three.
//   A character is registered on acceptance and processed once the result
//   buffer has room. Throughput is one character per cycle while in_stall
//   is low. A character that causes two or three results occupies the
//   four-entry result buffer, which drains one record per cycle while
//   out_stall is low; in_stall is high while a character waits in the input
//   register and the buffer holds more than one record.
//   While out_stall is high the head record holds steady and the buffer
//   fills, then in_stall rises.
//   Reset (arst_n low) empties the buffer and returns the tokenizer to the
//   start of a line with no words counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quoted_word_tokenizer_core #(
	parameter int MAX_WORD_LEN = qwt_pkg::MAX_WORD_LEN_DEF,
	parameter int MAX_WORDS    = qwt_pkg::MAX_WORDS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] ch,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      out_char,
	output logic [3:0]      word_index,
	output logic [4:0]      word_count,
	output logic            truncated,
	output logic            last
);

	logic                          valid_s1;
	logic [7:0]                    ch_s1;
	logic                          room, fire, accept;
	qwt_pkg::res_t                 res [qwt_pkg::MAX_RESULTS];
	logic [qwt_pkg::RES_CNT_W-1:0] res_cnt;
	qwt_pkg::res_t                 head;

	// Input register handshake
	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= ch;
		end
	end

	// Tokenizer step
	qwt_tokenizer #(
		.MAX_WORD_LEN(MAX_WORD_LEN),
		.MAX_WORDS   (MAX_WORDS)
	) u_tokenizer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (ch_s1),
		.res    (res),
		.res_cnt(res_cnt)
	);

	// Result buffer; nothing is pushed unless the step fires
	qwt_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_res (res),
		.push_cnt (fire ? res_cnt : '0),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	// Output fields
	assign kind       = head.kind;
	assign out_char   = head.out_char;
	assign word_index = head.word_index;
	assign word_count = head.word_count;
	assign truncated  = head.truncated;
	assign last       = head.last;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quoted_word_tokenizer_core. Lines of characters are
// queued up front: first a short directed set of lines, then random lines.
// Most random lines are well-formed words (plain, quoted, comment), with some
// oversized words, lines with too many words, noise and broken quoting. An
// in-bench tokenizer predicts every result record, and the monitor compares
// each accepted record field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int WORD_LIMIT  = qwt_pkg::MAX_WORD_LEN_DEF;
	localparam int COUNT_LIMIT = qwt_pkg::MAX_WORDS_DEF;
	localparam int RANDOM_CHARS = 175;
	localparam int IDLE_PCT     = 36;
	localparam int HOLD_CYCLES  = 48;
	localparam int HOLD_AFTER   = 60;
	localparam int REPORT_MAX   = 10;

	typedef enum int {
		SHAPE_PLAIN,
		SHAPE_LONG,
		SHAPE_MANY,
		SHAPE_NOISE,
		SHAPE_BROKEN
	} line_shape_t;

	// DUT ports
	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] ch = qwt_pkg::CH_END;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_char;
	logic [3:0] word_index;
	logic [4:0] word_count;
	logic       truncated;
	logic       last;

	// Stimulus and scoreboard
	logic [7:0]    char_q[$];
	qwt_pkg::res_t expected_tokens[$];
	qwt_pkg::res_t burst[$];
	int            total_chars = 0;
	int            chars_sent = 0;
	int            chars_taken = 0;
	int            errors = 0;
	logic          ch_taken = 1'b0;
	int            hold_left = 0;
	logic          hold_done = 1'b0;
	logic          quiet;
	logic          no_gaps;

	// Tokenizer state of the predictor
	logic       between_words = 1'b1;
	logic       in_quote = 1'b0;
	logic [5:0] word_len = '0;
	logic [4:0] words_kept = '0;
	logic       slash_held = 1'b0;
	logic       comment_on = 1'b0;
	logic       overflow = 1'b0;

	quoted_word_tokenizer_core #(
		.MAX_WORD_LEN(WORD_LIMIT),
		.MAX_WORDS(COUNT_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_char(out_char),
		.word_index(word_index),
		.word_count(word_count),
		.truncated(truncated),
		.last(last)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function void push_token(qwt_pkg::kind_t k, logic [7:0] c, logic [4:0] cnt, logic tr);
		qwt_pkg::res_t r;
		r.kind       = k;
		r.out_char   = c;
		r.word_index = (k == qwt_pkg::KIND_EOL) ? 4'd0 : words_kept[3:0];
		r.word_count = cnt;
		r.truncated  = tr;
		r.last       = 1'b0;
		burst.push_back(r);
	endfunction

	function logic word_dropped();
		return comment_on || words_kept >= COUNT_LIMIT;
	endfunction

	function void append_char(logic [7:0] c);
		logic [7:0] lc;
		lc = c;
		if (word_dropped())
			return;
		if (lc >= qwt_pkg::CH_UC_A && lc <= qwt_pkg::CH_UC_Z)
			lc = lc + qwt_pkg::CASE_OFS;
		// a leading slash waits until the next character decides
		if (word_len == 0 && lc == qwt_pkg::CH_SLASH) begin
			slash_held = 1'b1;
			word_len = 6'd1;
			return;
		end
		if (slash_held) begin
			slash_held = 1'b0;
			if (lc == qwt_pkg::CH_SLASH) begin
				comment_on = 1'b1;
				return;
			end
			push_token(qwt_pkg::KIND_CHAR, qwt_pkg::CH_SLASH, '0, 1'b0);
		end
		if (word_len >= WORD_LIMIT) begin
			overflow = 1'b1;
			return;
		end
		push_token(qwt_pkg::KIND_CHAR, lc, '0, 1'b0);
		word_len = word_len + 1'b1;
	endfunction

	function void close_word();
		between_words = 1'b1;
		in_quote = 1'b0;
		if (word_dropped())
			return;
		if (slash_held) begin
			slash_held = 1'b0;
			push_token(qwt_pkg::KIND_CHAR, qwt_pkg::CH_SLASH, '0, 1'b0);
		end
		push_token(qwt_pkg::KIND_EOW, '0, '0, 1'b0);
		words_kept = words_kept + 1'b1;
	endfunction

	function void tokenize_char(logic [7:0] c);
		burst = {};
		if (c == qwt_pkg::CH_END) begin
			if (!between_words)
				close_word();
			push_token(qwt_pkg::KIND_EOL, '0, words_kept, overflow);
			between_words = 1'b1;
			in_quote = 1'b0;
			word_len = '0;
			words_kept = '0;
			slash_held = 1'b0;
			comment_on = 1'b0;
			overflow = 1'b0;
		end else if (between_words) begin
			if (c != qwt_pkg::CH_SPACE) begin
				between_words = 1'b0;
				word_len = '0;
				slash_held = 1'b0;
				if (!comment_on && words_kept >= COUNT_LIMIT)
					overflow = 1'b1;
				if (c == qwt_pkg::CH_QUOTE)
					in_quote = 1'b1;
				else
					append_char(c);
			end
		end else if (in_quote) begin
			if (c == qwt_pkg::CH_QUOTE)
				close_word();
			else
				append_char(c);
		end else begin
			if (c == qwt_pkg::CH_SPACE)
				close_word();
			else if (c != qwt_pkg::CH_QUOTE)
				append_char(c);
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			expected_tokens.push_back(burst[i]);
	endfunction

	// ------------------------------------------------------------------------
	// Line generation
	// ------------------------------------------------------------------------
	function logic [7:0] word_byte(logic quoted);
		logic [7:0] b;
		case ($urandom_range(0, 15))
			6, 7: b = 8'($urandom_range(65, 90));
			8: begin
				b = 8'($urandom_range(33, 126));
				if (b == qwt_pkg::CH_QUOTE)
					b = b + 1'b1;
			end
			9: b = 8'($urandom_range(128, 255));
			10: b = qwt_pkg::CH_SLASH;
			11: b = quoted ? qwt_pkg::CH_SPACE : qwt_pkg::CH_QUOTE;
			default: b = 8'($urandom_range(97, 122));
		endcase
		return b;
	endfunction

	task put_word(int len);
		int style;
		style = $urandom_range(0, 9);
		if (style >= 7 && style <= 8) begin
			// quoted word, closing quote sometimes missing
			char_q.push_back(qwt_pkg::CH_QUOTE);
			repeat (len) char_q.push_back(word_byte(1'b1));
			if ($urandom_range(0, 4) != 0)
				char_q.push_back(qwt_pkg::CH_QUOTE);
		end else if (style == 9) begin
			char_q.push_back(qwt_pkg::CH_SLASH);
			char_q.push_back(qwt_pkg::CH_SLASH);
			repeat (len) char_q.push_back(word_byte(1'b0));
		end else begin
			repeat (len) char_q.push_back(word_byte(1'b0));
		end
	endtask

	task put_line(line_shape_t shape);
		int n;
		case (shape)
			SHAPE_LONG: begin
				repeat ($urandom_range(33, 40))
					char_q.push_back(8'($urandom_range(65, 122)));
				char_q.push_back(qwt_pkg::CH_SPACE);
				put_word($urandom_range(1, 4));
			end
			SHAPE_MANY: begin
				n = $urandom_range(15, 19);
				for (int w = 0; w < n; w++) begin
					repeat ($urandom_range(1, 2))
						char_q.push_back(8'($urandom_range(97, 122)));
					repeat ($urandom_range(1, 2)) char_q.push_back(qwt_pkg::CH_SPACE);
				end
			end
			SHAPE_NOISE: begin
				repeat ($urandom_range(1, 8)) char_q.push_back(8'($urandom_range(1, 255)));
			end
			SHAPE_BROKEN: begin
				repeat ($urandom_range(2, 8)) begin
					case ($urandom_range(0, 3))
						0: char_q.push_back(qwt_pkg::CH_QUOTE);
						1: char_q.push_back(qwt_pkg::CH_SLASH);
						2: char_q.push_back(qwt_pkg::CH_SPACE);
						default: char_q.push_back(8'($urandom_range(65, 90)));
					endcase
				end
			end
			default: begin
				n = $urandom_range(0, 5);
				for (int w = 0; w < n; w++) begin
					repeat ($urandom_range(0, 2)) char_q.push_back(qwt_pkg::CH_SPACE);
					put_word($urandom_range(1, 8));
					if (w < n - 1)
						char_q.push_back(qwt_pkg::CH_SPACE);
				end
				if ($urandom_range(0, 3) == 0)
					char_q.push_back(qwt_pkg::CH_SPACE);
			end
		endcase
		char_q.push_back(qwt_pkg::CH_END);
	endtask

	// ------------------------------------------------------------------------
	// Sender: one character per transaction, random gaps
	// ------------------------------------------------------------------------
	assign quiet   = chars_sent >= 130 && chars_sent < 190;
	assign no_gaps = quiet || hold_left != 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || ch_taken) begin
				if (char_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid   <= 1'b1;
					ch         <= char_q.pop_front();
					chars_sent <= chars_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off so the result buffer fills and input stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && chars_sent >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver stall
	always @(negedge clk) begin
		out_stall <= arst_n && (hold_left != 0 || (!quiet && $urandom_range(0, 99) < IDLE_PCT));
	end

	// ------------------------------------------------------------------------
	// Acceptance and result check
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		qwt_pkg::res_t want;
		ch_taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			tokenize_char(ch);
			chars_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: kind %0d char %02h word %0d count %0d",
						kind, out_char, word_index, word_count);
			end else begin
				want = expected_tokens.pop_front();
				if (kind !== want.kind || out_char !== want.out_char ||
						word_index !== want.word_index || word_count !== want.word_count ||
						truncated !== want.truncated || last !== want.last) begin
					errors++;
					if (errors <= REPORT_MAX) begin
						$display("mismatch: want kind %0d char %02h word %0d count %0d tr %0d last %0d",
							want.kind, want.out_char, want.word_index, want.word_count,
							want.truncated, want.last);
						$display("          got  kind %0d char %02h word %0d count %0d tr %0d last %0d",
							kind, out_char, word_index, word_count, truncated, last);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int random_start;
		int pick;
		// empty line
		char_q.push_back(qwt_pkg::CH_END);
		// case folding edges, high bytes
		char_q.push_back("A");
		char_q.push_back("Z");
		char_q.push_back("@");
		char_q.push_back("[");
		char_q.push_back(8'hFF);
		char_q.push_back(8'h80);
		char_q.push_back(qwt_pkg::CH_END);
		// lone slash, slash-led word with a dropped quote, empty quoted word,
		// quoted words back to back, unclosed quote
		char_q.push_back(qwt_pkg::CH_SLASH);
		char_q.push_back(qwt_pkg::CH_SPACE);
		char_q.push_back(qwt_pkg::CH_SLASH);
		char_q.push_back("a");
		char_q.push_back(qwt_pkg::CH_QUOTE);
		char_q.push_back(qwt_pkg::CH_SPACE);
		char_q.push_back(qwt_pkg::CH_QUOTE);
		char_q.push_back(qwt_pkg::CH_QUOTE);
		char_q.push_back(qwt_pkg::CH_QUOTE);
		char_q.push_back("q");
		char_q.push_back(qwt_pkg::CH_QUOTE);
		char_q.push_back(qwt_pkg::CH_QUOTE);
		char_q.push_back("u");
		char_q.push_back(qwt_pkg::CH_SPACE);
		char_q.push_back(qwt_pkg::CH_END);
		// comment word suppresses what follows
		char_q.push_back(qwt_pkg::CH_SLASH);
		char_q.push_back(qwt_pkg::CH_SLASH);
		char_q.push_back(qwt_pkg::CH_SPACE);
		char_q.push_back("d");
		char_q.push_back(qwt_pkg::CH_END);

		// random lines; an oversized word and a crowded line come first
		random_start = char_q.size();
		put_line(SHAPE_LONG);
		put_line(SHAPE_MANY);
		while (char_q.size() - random_start < RANDOM_CHARS) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: put_line(SHAPE_LONG);
				1: put_line(SHAPE_MANY);
				2: put_line(SHAPE_NOISE);
				3: put_line(SHAPE_BROKEN);
				default: put_line(SHAPE_PLAIN);
			endcase
		end
		total_chars = char_q.size();

		while (chars_taken < total_chars)
			@(posedge clk);
		while (expected_tokens.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_tokens.size() == 0)
			$display("[quoted_word_tokenizer_core] OK");
		else
			$display("[quoted_word_tokenizer_core] ERROR");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("[quoted_word_tokenizer_core] ERROR");
		$finish;
	end

endmodule
